FILE: hdl/smp_pkg.sv
`default_nettype none

package smp_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int CORDIC_STAGES_DEF   = 24;
    localparam int DIV_STEPS           = 60;
    localparam int NORM_STEPS          = 6;

    localparam int LAT_W    = 24;
    localparam int LON_W    = 25;
    localparam int EAST_W   = 26;
    localparam int NORTH_W  = 28;
    localparam int RADIUS_W = 23;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

    localparam logic signed [63:0] ONE_Q60        = 64'sh1000_0000_0000_0000;
    localparam logic [63:0]        PI_Q60         = 64'h3243_F6A8_885A_308D;
    localparam logic signed [63:0] QUARTER_PI_Q60 = 64'sh0C90_FDAA_2216_8C23;
    localparam logic [63:0]        LN2_Q60        = 64'h0B17_217F_7D1C_F79B;

    localparam logic [63:0] RAD_PER_DEG_Q32     = (PI_Q60 / 180) >> 28;
    localparam logic [63:0] RAD_PER_HALFDEG_Q38 = (PI_Q60 / 360) >> 22;
    localparam logic signed [63:0] LN2_Q56      = $signed(LN2_Q60 >> 4);

    localparam logic [63:0] EAST_MAX  = 64'd33554431;
    localparam logic [63:0] NORTH_MAX = 64'd134217727;

    typedef struct packed {
        logic                     lat_neg;
        logic                     pole;
        logic signed [EAST_W-1:0] east;
    } t_side;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } t_circ;

    typedef struct packed {
        logic signed [63:0]          x;
        logic signed [63:0]          y;
        logic signed [63:0]          z;
        logic signed [7:0]           e;
        logic [DIV_STEPS-1:0]        q;
        logic                        neg;
    } t_lane;

    typedef t_lane [1:0] t_ln;

    typedef struct packed {
        logic signed [EAST_W-1:0]  easting_m;
        logic signed [NORTH_W-1:0] northing_m;
        logic                      saturated;
    } t_result;

    function automatic logic signed [63:0] f_angle(input int i, input logic hyp);
        logic signed [63:0] acc;
        logic [63:0]        term;
        acc = '0;
        if (!hyp && i == 0) return QUARTER_PI_Q60;
        if (i <= 0 || i > 60) return '0;
        for (int k = 0; k < 31; k++) begin
            if (i * (2 * k + 1) <= 60) begin
                term = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
                if (hyp || (k & 1) == 0) begin
                    acc = acc + $signed(term);
                end else begin
                    acc = acc - $signed(term);
                end
            end
        end
        return acc;
    endfunction

    function automatic int f_hyp_shift(input int k);
        if (k < 4) return k + 1;
        if (k < 14) return k;
        return k - 1;
    endfunction

    function automatic int f_hyp_steps(input int stages);
        return stages + 1 + ((stages >= 13) ? 1 : 0);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/smp_stream_ifs.sv
`default_nettype none

interface smp_point_if;
    import smp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] latitude_deg;
    logic signed [LON_W-1:0] longitude_deg;
    modport source (output valid, output latitude_deg, output longitude_deg, input ready);
    modport sink   (input valid, input latitude_deg, input longitude_deg, output ready);
endinterface

interface smp_proj_if;
    import smp_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [EAST_W-1:0]  easting_m;
    logic signed [NORTH_W-1:0] northing_m;
    logic                      saturated;
    modport source (output valid, output easting_m, output northing_m, output saturated,
                    input ready);
    modport sink   (input valid, input easting_m, input northing_m, input saturated,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/smp_circ_cell.sv
`default_nettype none

module smp_circ_cell #(
    parameter int SHIFT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_v,
    input  smp_pkg::t_side i_side,
    input  smp_pkg::t_circ i_d,
    output logic           o_v,
    output smp_pkg::t_side o_side,
    output smp_pkg::t_circ o_d
);
    import smp_pkg::*;

    localparam logic signed [63:0] ANGLE = f_angle(SHIFT, 1'b0);

    logic               r_v;
    t_side              r_side;
    t_circ              r_d;
    t_circ              n_d;
    logic signed [63:0] xs;
    logic signed [63:0] ys;

    always_comb begin
        xs  = i_d.x >>> SHIFT;
        ys  = i_d.y >>> SHIFT;
        n_d = i_d;
        if (i_d.z >= 0) begin
            n_d.x = i_d.x - ys;
            n_d.y = i_d.y + xs;
            n_d.z = i_d.z - ANGLE;
        end else begin
            n_d.x = i_d.x + ys;
            n_d.y = i_d.y - xs;
            n_d.z = i_d.z + ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_d    <= n_d;
        end
    end

    assign o_v    = r_v;
    assign o_side = r_side;
    assign o_d    = r_d;

endmodule

`default_nettype wire

FILE: hdl/smp_norm_cell.sv
`default_nettype none

module smp_norm_cell #(
    parameter int SHIFT = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_v,
    input  smp_pkg::t_side i_side,
    input  smp_pkg::t_ln   i_d,
    output logic           o_v,
    output smp_pkg::t_side o_side,
    output smp_pkg::t_ln   o_d
);
    import smp_pkg::*;

    localparam logic [63:0] LIMIT = 64'd1 << (61 - SHIFT);

    logic  r_v;
    t_side r_side;
    t_ln   r_d;
    t_ln   n_d;

    always_comb begin
        n_d = i_d;
        for (int j = 0; j < 2; j++) begin
            if ($unsigned(i_d[j].x) < LIMIT) begin
                n_d[j].x = i_d[j].x <<< SHIFT;
                n_d[j].e = i_d[j].e - 8'(SHIFT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_d    <= n_d;
        end
    end

    assign o_v    = r_v;
    assign o_side = r_side;
    assign o_d    = r_d;

endmodule

`default_nettype wire

FILE: hdl/smp_hyp_cell.sv
`default_nettype none

module smp_hyp_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_v,
    input  smp_pkg::t_side i_side,
    input  smp_pkg::t_ln   i_d,
    output logic           o_v,
    output smp_pkg::t_side o_side,
    output smp_pkg::t_ln   o_d
);
    import smp_pkg::*;

    localparam int SHIFT = f_hyp_shift(STEP);
    localparam logic signed [63:0] ANGLE = f_angle(SHIFT, 1'b1);

    logic               r_v;
    t_side              r_side;
    t_ln                r_d;
    t_ln                n_d;
    logic signed [63:0] xs;
    logic signed [63:0] ys;

    always_comb begin
        n_d = i_d;
        xs  = '0;
        ys  = '0;
        for (int j = 0; j < 2; j++) begin
            xs = i_d[j].x >>> SHIFT;
            ys = i_d[j].y >>> SHIFT;
            if (i_d[j].y >= 0) begin
                n_d[j].x = i_d[j].x - ys;
                n_d[j].y = i_d[j].y - xs;
                n_d[j].z = i_d[j].z + ANGLE;
            end else begin
                n_d[j].x = i_d[j].x + ys;
                n_d[j].y = i_d[j].y + xs;
                n_d[j].z = i_d[j].z - ANGLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_d    <= n_d;
        end
    end

    assign o_v    = r_v;
    assign o_side = r_side;
    assign o_d    = r_d;

endmodule

`default_nettype wire

FILE: hdl/smp_div_cell.sv
`default_nettype none

module smp_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_v,
    input  smp_pkg::t_side i_side,
    input  smp_pkg::t_ln   i_d,
    output logic           o_v,
    output smp_pkg::t_side o_side,
    output smp_pkg::t_ln   o_d
);
    import smp_pkg::*;

    logic        r_v;
    t_side       r_side;
    t_ln         r_d;
    t_ln         n_d;
    logic [63:0] rem2;
    logic        ge;

    // The y field holds the partial remainder and x the divisor.
    always_comb begin
        n_d  = i_d;
        rem2 = '0;
        ge   = 1'b0;
        for (int j = 0; j < 2; j++) begin
            rem2     = {i_d[j].y[62:0], 1'b0};
            ge       = rem2 >= $unsigned(i_d[j].x);
            n_d[j].y = $signed(ge ? rem2 - $unsigned(i_d[j].x) : rem2);
            n_d[j].q = {i_d[j].q[DIV_STEPS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_d    <= n_d;
        end
    end

    assign o_v    = r_v;
    assign o_side = r_side;
    assign o_d    = r_d;

endmodule

`default_nettype wire

FILE: hdl/spherical_mercator_project_top.sv
// Channel   Direction  Contents
// i_point   in         latitude_deg, longitude_deg
// o_proj    out        easting_m, northing_m, saturated
// i_cfg_*   in         sphere_radius_m write
//
// One point enters per cycle while the input is ready. Below 13 stages the hyperbolic
// chain has one repeated step less. A result passes through the circular chain, the
// hyperbolic chain and the 60-step divider.
// Reset is synchronous and clears the valid bits; the radius returns to 6371000.
// A skid entry behind the output register absorbs one result while the output stalls.
// The pipeline freezes, and the input is not ready, only while that entry is full.
`default_nettype none

module spherical_mercator_project_top #(
    parameter int ANGLE_FRAC_BITS = smp_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = smp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [smp_pkg::RADIUS_W-1:0]   i_cfg_data,
    smp_point_if.sink                      i_point,
    smp_proj_if.source                     o_proj
);
    import smp_pkg::*;

    localparam int NC  = CORDIC_STAGES;
    localparam int NH  = f_hyp_steps(CORDIC_STAGES);
    localparam int SH  = 22 - ANGLE_FRAC_BITS;
    localparam int SHL = (SH >= 0) ? SH : 0;
    localparam int SHR = (SH < 0) ? -SH : 0;
    localparam logic [63:0] POLE  = 64'd90 << ANGLE_FRAC_BITS;
    localparam logic [63:0] RHALF = 64'd1 << (ANGLE_FRAC_BITS - 1);

    logic [RADIUS_W-1:0] r_radius;
    logic                en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_data;
        end
    end

    // Stage 0: angle conversions.
    logic signed [LON_W:0] lon_x;
    logic signed [LAT_W:0] lat_x;
    logic [63:0]           lm;
    logic [63:0]           am;
    logic [63:0]           d;
    logic [63:0]           p;
    logic [63:0]           rad_sum;

    logic        r_s0_v;
    logic [63:0] r_s0_rad32;
    logic [63:0] r_s0_u;
    logic        r_s0_pole;
    logic        r_s0_lat_neg;
    logic        r_s0_lon_neg;

    always_comb begin
        lon_x   = (LON_W + 1)'(i_point.longitude_deg);
        lat_x   = (LAT_W + 1)'(i_point.latitude_deg);
        lm      = 64'(lon_x < 0 ? -lon_x : lon_x);
        am      = 64'(lat_x < 0 ? -lat_x : lat_x);
        if (am > POLE) am = POLE;
        d       = POLE - am;
        p       = d * RAD_PER_HALFDEG_Q38;
        rad_sum = lm * RAD_PER_DEG_Q32 + RHALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_point.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_rad32   <= rad_sum >> ANGLE_FRAC_BITS;
            r_s0_u       <= (p << SHL) >> SHR;
            r_s0_pole    <= (d == 64'd0);
            r_s0_lat_neg <= i_point.latitude_deg < 0;
            r_s0_lon_neg <= i_point.longitude_deg < 0;
        end
    end

    // Stage 1: easting and circular chain seed.
    logic [63:0] em;
    logic        r_s1_v;
    t_side       r_s1_side;
    t_circ       r_s1_d;

    always_comb begin
        em = 64'(r_radius) * {32'd0, r_s0_rad32[63:32]}
           + ((64'(r_radius) * {32'd0, r_s0_rad32[31:0]} + 64'h8000_0000) >> 32);
        if (em > EAST_MAX) em = EAST_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= r_s0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_side.lat_neg <= r_s0_lat_neg;
            r_s1_side.pole    <= r_s0_pole;
            r_s1_side.east    <= r_s0_lon_neg ? -$signed(em[EAST_W-1:0])
                                              : $signed(em[EAST_W-1:0]);
            r_s1_d.x          <= ONE_Q60;
            r_s1_d.y          <= '0;
            r_s1_d.z          <= $signed(r_s0_u);
        end
    end

    // Circular rotation chain.
    logic  c_v    [NC+1];
    t_side c_side [NC+1];
    t_circ c_d    [NC+1];

    assign c_v[0]    = r_s1_v;
    assign c_side[0] = r_s1_side;
    assign c_d[0]    = r_s1_d;

    for (genvar g = 0; g < NC; g++) begin : g_circ
        smp_circ_cell #(.SHIFT(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_v    (c_v[g]),
            .i_side (c_side[g]),
            .i_d    (c_d[g]),
            .o_v    (c_v[g+1]),
            .o_side (c_side[g+1]),
            .o_d    (c_d[g+1])
        );
    end

    // Residual-angle correction: partial products, then sums.
    logic [63:0] ma [2];
    logic [63:0] mz;
    logic        r_m1_v;
    t_side       r_m1_side;
    logic signed [63:0] r_m1_x;
    logic signed [63:0] r_m1_y;
    logic [63:0] r_m1_p [2][4];
    logic        r_m1_neg [2];

    always_comb begin
        ma[0] = c_d[NC].y < 0 ? 64'd0 - $unsigned(c_d[NC].y) : $unsigned(c_d[NC].y);
        ma[1] = c_d[NC].x < 0 ? 64'd0 - $unsigned(c_d[NC].x) : $unsigned(c_d[NC].x);
        mz    = c_d[NC].z < 0 ? 64'd0 - $unsigned(c_d[NC].z) : $unsigned(c_d[NC].z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
        end else if (en) begin
            r_m1_v <= c_v[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_side   <= c_side[NC];
            r_m1_x      <= c_d[NC].x;
            r_m1_y      <= c_d[NC].y;
            r_m1_neg[0] <= (c_d[NC].y < 0) != (c_d[NC].z < 0);
            r_m1_neg[1] <= (c_d[NC].x < 0) != (c_d[NC].z < 0);
            for (int j = 0; j < 2; j++) begin
                r_m1_p[j][0] <= {32'd0, ma[j][31:0]} * {32'd0, mz[31:0]};
                r_m1_p[j][1] <= {32'd0, ma[j][31:0]} * {32'd0, mz[63:32]};
                r_m1_p[j][2] <= {32'd0, ma[j][63:32]} * {32'd0, mz[31:0]};
                r_m1_p[j][3] <= {32'd0, ma[j][63:32]} * {32'd0, mz[63:32]};
            end
        end
    end

    logic [127:0]       full [2];
    logic signed [63:0] mq   [2];
    logic signed [63:0] cs_c;
    logic signed [63:0] cs_s;

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            full[j] = {r_m1_p[j][3], 64'd0}
                    + ({64'd0, r_m1_p[j][1]} << 32)
                    + ({64'd0, r_m1_p[j][2]} << 32)
                    + {64'd0, r_m1_p[j][0]};
            mq[j]   = r_m1_neg[j] ? -$signed({2'b00, full[j][121:60]})
                                  : $signed({2'b00, full[j][121:60]});
        end
        cs_c = r_m1_x - mq[0];
        cs_s = r_m1_y + mq[1];
    end

    logic  r_m2_v;
    t_side r_m2_side;
    t_ln   r_m2_d;
    t_side n_m2_side;
    t_ln   n_m2_d;

    always_comb begin
        n_m2_side      = r_m1_side;
        n_m2_side.pole = r_m1_side.pole || (cs_s <= 0);
        n_m2_d         = '0;
        n_m2_d[0].x    = cs_c;
        n_m2_d[1].x    = cs_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_v <= 1'b0;
        end else if (en) begin
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_side <= n_m2_side;
            r_m2_d    <= n_m2_d;
        end
    end

    // Normalization to [1,2).
    logic  n_v    [NORM_STEPS+1];
    t_side n_side [NORM_STEPS+1];
    t_ln   n_dat  [NORM_STEPS+1];

    assign n_v[0]    = r_m2_v;
    assign n_side[0] = r_m2_side;
    assign n_dat[0]  = r_m2_d;

    for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
        smp_norm_cell #(.SHIFT(32 >> g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_v    (n_v[g]),
            .i_side (n_side[g]),
            .i_d    (n_dat[g]),
            .o_v    (n_v[g+1]),
            .o_side (n_side[g+1]),
            .o_d    (n_dat[g+1])
        );
    end

    // Hyperbolic vectoring chain.
    logic  h_v    [NH+1];
    t_side h_side [NH+1];
    t_ln   h_d    [NH+1];

    always_comb begin
        h_d[0] = n_dat[NORM_STEPS];
        for (int j = 0; j < 2; j++) begin
            h_d[0][j].x = n_dat[NORM_STEPS][j].x + ONE_Q60;
            h_d[0][j].y = n_dat[NORM_STEPS][j].x - ONE_Q60;
            h_d[0][j].z = '0;
        end
    end

    assign h_v[0]    = n_v[NORM_STEPS];
    assign h_side[0] = n_side[NORM_STEPS];

    for (genvar g = 0; g < NH; g++) begin : g_hyp
        smp_hyp_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_v    (h_v[g]),
            .i_side (h_side[g]),
            .i_d    (h_d[g]),
            .o_v    (h_v[g+1]),
            .o_side (h_side[g+1]),
            .o_d    (h_d[g+1])
        );
    end

    // Restoring division of the residual y by x.
    logic  dv_v    [DIV_STEPS+1];
    t_side dv_side [DIV_STEPS+1];
    t_ln   dv_d    [DIV_STEPS+1];

    always_comb begin
        dv_d[0] = h_d[NH];
        for (int j = 0; j < 2; j++) begin
            dv_d[0][j].neg = h_d[NH][j].y < 0;
            dv_d[0][j].y   = h_d[NH][j].y < 0 ? -h_d[NH][j].y : h_d[NH][j].y;
            dv_d[0][j].q   = '0;
        end
    end

    assign dv_v[0]    = h_v[NH];
    assign dv_side[0] = h_side[NH];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        smp_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_v    (dv_v[g]),
            .i_side (dv_side[g]),
            .i_d    (dv_d[g]),
            .o_v    (dv_v[g+1]),
            .o_side (dv_side[g+1]),
            .o_d    (dv_d[g+1])
        );
    end

    // Logarithm assembly and scaling by the radius.
    logic               r_l1_v;
    t_side              r_l1_side;
    logic signed [63:0] r_l1_z [2];
    logic signed [7:0]  r_l1_e [2];
    logic               r_l2_v;
    t_side              r_l2_side;
    logic signed [63:0] r_l2_ln [2];
    logic               r_l3_v;
    t_side              r_l3_side;
    logic [39:0]        r_l3_lmag;
    logic               r_l3_lneg;
    logic               r_l4_v;
    t_side              r_l4_side;
    logic [63:0]        r_l4_prod;
    logic               r_l4_lneg;
    logic signed [63:0] ldiff;
    logic signed [63:0] qv [2];

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            qv[j] = $signed({4'd0, dv_d[DIV_STEPS][j].q});
        end
        ldiff = r_l2_ln[0] - r_l2_ln[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_v <= 1'b0;
            r_l2_v <= 1'b0;
            r_l3_v <= 1'b0;
            r_l4_v <= 1'b0;
        end else if (en) begin
            r_l1_v <= dv_v[DIV_STEPS];
            r_l2_v <= r_l1_v;
            r_l3_v <= r_l2_v;
            r_l4_v <= r_l3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l1_side <= dv_side[DIV_STEPS];
            r_l2_side <= r_l1_side;
            r_l3_side <= r_l2_side;
            r_l4_side <= r_l3_side;
            for (int j = 0; j < 2; j++) begin
                r_l1_z[j]  <= dv_d[DIV_STEPS][j].z
                            + (dv_d[DIV_STEPS][j].neg ? -qv[j] : qv[j]);
                r_l1_e[j]  <= dv_d[DIV_STEPS][j].e;
                r_l2_ln[j] <= ((r_l1_z[j] <<< 1) >>> 4) + 64'(r_l1_e[j]) * LN2_Q56;
            end
            r_l3_lneg <= ldiff < 0;
            r_l3_lmag <= 40'($unsigned(ldiff < 0 ? -ldiff : ldiff) >> 24);
            r_l4_lneg <= r_l3_lneg;
            r_l4_prod <= 64'(r_radius) * {24'd0, r_l3_lmag};
        end
    end

    logic [63:0]               nsum;
    logic [31:0]               nm;
    logic signed [NORTH_W-1:0] north;
    t_result                   res;

    always_comb begin
        nsum          = r_l4_prod + 64'h8000_0000;
        nm            = nsum[63:32];
        res.saturated = 1'b0;
        if (r_l4_side.pole) begin
            north         = $signed(NORTH_MAX[NORTH_W-1:0]);
            res.saturated = 1'b1;
        end else begin
            if (64'(nm) > NORTH_MAX) begin
                nm            = NORTH_MAX[31:0];
                res.saturated = 1'b1;
            end
            north = r_l4_lneg ? -$signed(nm[NORTH_W-1:0]) : $signed(nm[NORTH_W-1:0]);
        end
        res.northing_m = r_l4_side.lat_neg ? -north : north;
        res.easting_m  = r_l4_side.east;
    end

    // Output register with a skid entry.
    logic    r_out_v;
    t_result r_out;
    logic    r_skid_v;
    t_result r_skid;
    logic    out_fire;

    assign en       = !r_skid_v;
    assign out_fire = r_out_v && o_proj.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_fire) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_l4_v) begin
            if (!r_out_v || out_fire) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (r_l4_v) begin
            if (!r_out_v || out_fire) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign i_point.ready     = en;
    assign o_proj.valid      = r_out_v;
    assign o_proj.easting_m  = r_out.easting_m;
    assign o_proj.northing_m = r_out.northing_m;
    assign o_proj.saturated  = r_out.saturated;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry filled while output register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !o_proj.ready))
        else $error("skid entry filled without an output stall");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_proj.valid && o_proj.saturated) |->
        (o_proj.northing_m == $signed(NORTH_MAX[NORTH_W-1:0]) ||
         o_proj.northing_m == -$signed(NORTH_MAX[NORTH_W-1:0])))
        else $error("saturated transaction without a limit northing");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smp_pkg::*;

    localparam int STAGES = 24;
    localparam longint unsigned PI_FX = 64'h3243_F6A8_885A_308D;
    localparam longint ONE_FX = 64'sh1000_0000_0000_0000;
    localparam longint QPI_FX = 64'sh0C90_FDAA_2216_8C23;
    localparam longint LN2_FX = 64'sh0B17_217F_7D1C_F79B;
    localparam longint unsigned DEG_TO_RAD = (PI_FX / 180) >> 28;
    localparam longint unsigned HALFDEG_TO_RAD = (PI_FX / 360) >> 22;
    localparam longint unsigned POLE_DEG = 64'd90 << 16;
    localparam longint unsigned EAST_LIM = 64'd33554431;
    localparam longint unsigned NORTH_LIM = 64'd134217727;
    localparam int SETTLE_CYCLES = 150;

    class proj_scoreboard;
        t_result expected_q[$];
        int errors;
        logic [RADIUS_W-1:0] radius;
        longint circ_angle[0:63];
        longint hyp_angle[0:63];

        function new();
            errors = 0;
            radius = 23'd6371000;
            for (int i = 0; i < 64; i++) begin
                circ_angle[i] = series_angle(i, 1'b0);
                hyp_angle[i] = series_angle(i, 1'b1);
            end
        endfunction

        function longint series_angle(int i, bit hyp);
            longint acc;
            longint term;
            acc = 0;
            if (!hyp && i == 0) return QPI_FX;
            if (i <= 0 || i > 60) return 0;
            for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
                term = longint'((64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1));
                acc = (hyp || (k % 2) == 0) ? acc + term : acc - term;
            end
            return acc;
        endfunction

        function longint mul_fx(longint a, longint b);
            logic [127:0] p;
            longint unsigned ua, ub, r;
            ua = a < 0 ? -a : a;
            ub = b < 0 ? -b : b;
            p = 128'(ua) * 128'(ub);
            r = {2'b00, p[121:60]};
            return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
        endfunction

        function longint unsigned div_fx(longint unsigned num, longint unsigned den);
            logic [127:0] q;
            if (den == 0) return 0;
            q = {64'd0, num % den} << 60;
            q = q / den;
            return q[63:0];
        endfunction

        function void hyp_step(inout longint x, inout longint y, inout longint z, input int i);
            longint xs, ys;
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x -= ys; y -= xs; z += hyp_angle[i];
            end else begin
                x += ys; y += xs; z -= hyp_angle[i];
            end
        endfunction

        function longint log_fx(longint v);
            int e;
            longint x, y, z, corr;
            longint unsigned ym;
            e = 0;
            z = 0;
            if (v <= 0) return 0;
            while (v >= 2 * ONE_FX) begin
                v = v >>> 1; e++;
            end
            while (v < ONE_FX) begin
                v = v <<< 1; e--;
            end
            x = v + ONE_FX;
            y = v - ONE_FX;
            for (int i = 1; i <= STAGES; i++) begin
                hyp_step(x, y, z, i);
                if (i == 4 || i == 13) hyp_step(x, y, z, i);
            end
            ym = y < 0 ? -y : y;
            corr = longint'(div_fx(ym, x));
            z = y < 0 ? z - corr : z + corr;
            return ((2 * z) >>> 4) + longint'(e) * (LN2_FX >>> 4);
        endfunction

        function void rotate(longint u, output longint c, output longint s);
            longint x, y, z, xs, ys;
            x = ONE_FX;
            y = 0;
            z = u;
            for (int i = 0; i < STAGES; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= circ_angle[i];
                end else begin
                    x += ys; y -= xs; z += circ_angle[i];
                end
            end
            c = x - mul_fx(y, z);
            s = y + mul_fx(x, z);
        endfunction

        function t_result project(logic signed [LAT_W-1:0] lat_in,
                                  logic signed [LON_W-1:0] lon_in);
            longint lat, lon, east, north, c, s, l;
            longint unsigned r, lm, am, rad, em, nm, d, lmag;
            bit sat;
            t_result res;
            lat = lat_in;
            lon = lon_in;
            r = radius;
            sat = 0;
            lm = lon < 0 ? -lon : lon;
            am = lat < 0 ? -lat : lat;
            rad = (lm * DEG_TO_RAD + 64'd32768) >> 16;
            em = r * (rad >> 32) + ((r * (rad & 64'hFFFF_FFFF) + 64'h8000_0000) >> 32);
            if (em > EAST_LIM) em = EAST_LIM;
            east = lon < 0 ? -longint'(em) : longint'(em);
            if (am > POLE_DEG) am = POLE_DEG;
            d = POLE_DEG - am;
            if (d == 0) begin
                sat = 1;
                north = NORTH_LIM;
            end else begin
                rotate(longint'((d * HALFDEG_TO_RAD) << 6), c, s);
                if (s <= 0) begin
                    sat = 1;
                    north = NORTH_LIM;
                end else begin
                    l = log_fx(c) - log_fx(s);
                    lmag = l < 0 ? -l : l;
                    nm = (r * (lmag >> 24) + 64'h8000_0000) >> 32;
                    if (nm > NORTH_LIM) begin
                        nm = NORTH_LIM;
                        sat = 1;
                    end
                    north = l < 0 ? -longint'(nm) : longint'(nm);
                end
            end
            if (lat < 0) north = -north;
            res.easting_m = east[EAST_W-1:0];
            res.northing_m = north[NORTH_W-1:0];
            res.saturated = sat;
            return res;
        endfunction

        function void note_point(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon);
            expected_q.push_back(project(lat, lon));
        endfunction

        task report(string msg);
            $display("ERROR %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected transaction e=%0d n=%0d s=%0d",
                                 got.easting_m, got.northing_m, got.saturated));
                return;
            end
            want = expected_q.pop_front();
            if (got.easting_m !== want.easting_m)
                report($sformatf("easting %0d, want %0d", got.easting_m, want.easting_m));
            if (got.northing_m !== want.northing_m)
                report($sformatf("northing %0d, want %0d", got.northing_m, want.northing_m));
            if (got.saturated !== want.saturated)
                report($sformatf("saturated %0b, want %0b", got.saturated, want.saturated));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [RADIUS_W-1:0] i_cfg_data = '0;
    bit sink_steady = 1'b0;
    bit src_steady = 1'b0;
    int stall_left = 0;

    smp_point_if pt ();
    smp_proj_if pr ();

    proj_scoreboard sb = new();

    spherical_mercator_project_top uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_point(pt),
        .o_proj(pr)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        pt.valid = 1'b0;
        pt.latitude_deg = '0;
        pt.longitude_deg = '0;
        pr.ready = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pr.ready <= 1'b0;
        end else if (sink_steady) begin
            pr.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            pr.ready <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            pr.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pr.valid && pr.ready)
            sb.check_result('{pr.easting_m, pr.northing_m, pr.saturated});
    end

    task send_point(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon);
        int gap;
        pt.valid <= 1'b1;
        pt.latitude_deg <= lat;
        pt.longitude_deg <= lon;
        do @(posedge i_clk); while (!pt.ready);
        sb.note_point(lat, lon);
        @(negedge i_clk);
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0) begin
            pt.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task drain();
        if (pt.valid) begin
            pt.valid <= 1'b0;
            @(negedge i_clk);
        end
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task write_radius(logic [RADIUS_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.radius = value;
        @(negedge i_clk);
    endtask

    task send_random(int count);
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                lat = LAT_W'($urandom);
                lon = LON_W'($urandom);
            end else begin
                lat = LAT_W'($signed($urandom_range(0, 2 * 5898240)) - 5898240);
                lon = LON_W'($signed($urandom_range(0, 2 * 11796480)) - 11796480);
                if ($urandom_range(0, 9) == 0)
                    lat = LAT_W'((lat < 0 ? -5898240 : 5898240)
                                 - ($signed($urandom_range(0, 404)) - 4));
            end
            send_point(lat, lon);
        end
    endtask

    task send_directed();
        send_point(24'sd0, 25'sd0);
        send_point(24'sd1, 25'sd1);
        send_point(-24'sd1, -25'sd1);
        send_point(24'sd5898240, 25'sd11796480);
        send_point(-24'sd5898240, -25'sd11796480);
        send_point(24'sd5898239, 25'sd11796479);
        send_point(-24'sd5898239, -25'sd11796479);
        send_point(24'sd5898241, 25'sd11796481);
        send_point(24'sd8388607, 25'sd16777215);
        send_point(-24'sd8388608, -25'sd16777216);
        send_point(24'sd5570560, -25'sd5898240);
        send_point(-24'sd5570560, 25'sd5898240);
        send_point(24'sd2949120, 25'sd65536);
        send_point(24'sd5898176, 25'sd0);
        send_point(-24'sd5898176, 25'sd0);
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_directed();
        send_random(150);
        drain();

        write_radius(23'd1);
        send_directed();
        send_random(60);
        drain();

        write_radius(23'd8388607);
        sink_steady = 1'b1;
        src_steady = 1'b1;
        send_directed();
        send_random(150);
        drain();
        sink_steady = 1'b0;
        src_steady = 1'b0;

        write_radius(23'd0);
        send_directed();
        send_random(30);
        drain();

        write_radius(23'($urandom_range(1, 8388607)));
        send_random(200);
        drain();
        send_random(100);

        drain();
        write_radius(23'd6371000);
        send_random(300);
        drain();

        if (sb.errors == 0) begin
            $display("spherical_mercator_project_top: match");
        end else begin
            $display("spherical_mercator_project_top: mismatch");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("spherical_mercator_project_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
